// ===== sv/hid_keyboard_report_builder_defines.svh =====
// ----------------------------------------------------------------------------
// HID keyboard report builder assertion macros
// Shared macros for the concurrent checks of the report builder.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKRB_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkrb check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define HKRB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkrb check failed: next-cycle rule");

`endif

// ===== sv/hkrb_pkg.sv =====
// ----------------------------------------------------------------------------
// HID keyboard report builder package
// Matrix geometry, event and report layouts, and controller state codes.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  // Key matrix geometry and derived memory sizes.
  localparam int ROWS       = 8;
  localparam int COLS       = 16;
  localparam int ENTRIES    = ROWS * COLS;
  localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  // Report layout.
  localparam int SLOTS      = 6;
  localparam int SLOT_IDX_W = $clog2(SLOTS);
  localparam int FOUND_W    = $clog2(SLOTS + 1);
  localparam int KEY_W      = 8;
  localparam int MOD_W      = 8;
  localparam logic [KEY_W-1:0] ROLLOVER_CODE = 8'd1;

  // Field widths of one event.
  localparam int ACT_W      = 3;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  // Event kinds carried on the input side-band.
  typedef enum logic [ACT_W-1:0] {
    ACT_PRESS        = 3'd0,
    ACT_RELEASE      = 3'd1,
    ACT_SET_HARD     = 3'd2,
    ACT_CLR_HARD     = 3'd3,
    ACT_SET_WEAK     = 3'd4,
    ACT_CLR_WEAK     = 3'd5,
    ACT_CLR_ALL_WEAK = 3'd6,
    ACT_BUILD        = 3'd7
  } action_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Input data word, last field in the lowest bits.
  typedef struct packed {
    logic             reserved;
    logic [MOD_W-1:0] mod_mask;
    logic [KEY_W-1:0] key_code;
    logic [COL_W-1:0] key_col;
    logic [ROW_W-1:0] key_row;
  } event_t;

  // Output data word, report modifier in the lowest byte.
  typedef struct packed {
    logic [5:0]                  reserved;
    logic                        changed;
    logic                        rolled_over;
    logic [SLOTS-1:0][KEY_W-1:0] slot;
    logic [MOD_W-1:0]            report_modifier;
  } report_t;

endpackage

// ===== sv/hid_keyboard_report_builder.sv =====
// ----------------------------------------------------------------------------
// HID keyboard report builder
// Holds a keycode per matrix position in a memory and builds 6-key reports.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Carries
// -------  ---------  ---------------------------------------------------
// s_*      in         one keyboard event per transfer (kind on s_tuser)
// m_*      out        one boot keyboard report per build event
//
// Press, release and modifier events are taken only while idle.
// A build passes through scan, drain and finish: the single read port of
// the key memory visits every matrix position once in order.
// After reset a clearing pass writes zero to all ENTRIES positions;
// s_tready stays low during it.
// A finished report waits in the output register; events keep flowing, and
// a later build holds in its last step until that register is free.

module hid_keyboard_report_builder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // key_row[2:0], key_col[6:3], key_code[14:7], mod_mask[22:15], zero pad
  input  logic [hkrb_pkg::IN_DATA_W-1:0]   s_tdata,
  // action[2:0]
  input  logic [hkrb_pkg::ACT_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // report_modifier[7:0], slot0[15:8] .. slot5[55:48], rolled_over[56],
  // changed[57], zero pad
  output logic [hkrb_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // Key memory and its registered read port.
  logic [hkrb_pkg::KEY_W-1:0] key_mem [hkrb_pkg::ENTRIES];
  logic [hkrb_pkg::KEY_W-1:0] rd_data;
  logic                       rd_pend;

  // Controller.
  hkrb_pkg::state_t           state;
  hkrb_pkg::state_t           state_next;
  logic [hkrb_pkg::CNT_W-1:0] cnt;
  logic                       cnt_last;

  // Scan accumulators.
  logic [hkrb_pkg::FOUND_W-1:0]                  found;
  logic                                          over;
  logic [hkrb_pkg::SLOTS-1:0][hkrb_pkg::KEY_W-1:0] slots;

  // Modifier state.
  logic [hkrb_pkg::MOD_W-1:0] hard_mask;
  logic [hkrb_pkg::MOD_W-1:0] weak_mask;
  logic [hkrb_pkg::MOD_W-1:0] last_modifier;
  logic                       pending;

  // Output register.
  hkrb_pkg::report_t report;

  // Decoded input.
  hkrb_pkg::event_t            ev;
  hkrb_pkg::action_t           act;
  logic                        accept;
  logic                        key_event;
  logic                        in_range;
  logic [hkrb_pkg::ADDR_W-1:0] key_addr;

  // Memory write port.
  logic                        mem_we;
  logic [hkrb_pkg::ADDR_W-1:0] mem_waddr;
  logic [hkrb_pkg::KEY_W-1:0]  mem_wdata;

  // Report emission.
  logic                        out_free;
  logic                        emit;
  logic [hkrb_pkg::MOD_W-1:0]  combined_mod;

  // Input decode.
  assign ev        = hkrb_pkg::event_t'(s_tdata);
  assign act       = hkrb_pkg::action_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign key_event = (act == hkrb_pkg::ACT_PRESS) || (act == hkrb_pkg::ACT_RELEASE);
  assign in_range  = (int'(ev.key_row) < hkrb_pkg::ROWS) &&
                     (int'(ev.key_col) < hkrb_pkg::COLS);
  assign key_addr  = hkrb_pkg::ADDR_W'(int'(ev.key_row) * hkrb_pkg::COLS +
                                       int'(ev.key_col));

  assign cnt_last     = (cnt == hkrb_pkg::CNT_W'(hkrb_pkg::ENTRIES - 1));
  assign out_free     = !m_tvalid || m_tready;
  assign combined_mod = hard_mask | weak_mask;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      hkrb_pkg::ST_CLEAR: begin
        if (cnt_last) state_next = hkrb_pkg::ST_IDLE;
      end
      hkrb_pkg::ST_IDLE: begin
        if (accept && (act == hkrb_pkg::ACT_BUILD)) state_next = hkrb_pkg::ST_SCAN;
      end
      hkrb_pkg::ST_SCAN: begin
        if (cnt_last) state_next = hkrb_pkg::ST_DRAIN;
      end
      hkrb_pkg::ST_DRAIN: begin
        state_next = hkrb_pkg::ST_FINISH;
      end
      hkrb_pkg::ST_FINISH: begin
        if (out_free) state_next = hkrb_pkg::ST_IDLE;
      end
      default: begin
        state_next = hkrb_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs: handshake, memory write port and report emission.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = key_addr;
    mem_wdata = '0;
    emit      = 1'b0;
    case (state)
      hkrb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[hkrb_pkg::ADDR_W-1:0];
      end
      hkrb_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        mem_we    = s_tvalid && key_event && in_range;
        mem_wdata = (act == hkrb_pkg::ACT_PRESS) ? ev.key_code : '0;
      end
      hkrb_pkg::ST_FINISH: begin
        emit = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State register and position counter shared by clearing and scanning.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hkrb_pkg::ST_CLEAR;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == hkrb_pkg::ST_SCAN);
      if ((state == hkrb_pkg::ST_CLEAR) || (state == hkrb_pkg::ST_SCAN)) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
    end
  end

  // Key memory: one write port, one registered read port at the scan address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= key_mem[cnt[hkrb_pkg::ADDR_W-1:0]];
  end

  // Scan accumulators: collect the first six nonzero keys, flag a seventh.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= '0;
      over  <= 1'b0;
    end else if (accept && (act == hkrb_pkg::ACT_BUILD)) begin
      found <= '0;
      over  <= 1'b0;
    end else if (rd_pend && (rd_data != '0)) begin
      if (found == hkrb_pkg::FOUND_W'(hkrb_pkg::SLOTS)) begin
        over <= 1'b1;
      end else begin
        found <= found + 1'b1;
      end
    end
  end

  // Slot contents are payload only.
  always_ff @(posedge clk) begin
    if (accept && (act == hkrb_pkg::ACT_BUILD)) begin
      slots <= '0;
    end else if (rd_pend && (rd_data != '0) &&
                 (found != hkrb_pkg::FOUND_W'(hkrb_pkg::SLOTS))) begin
      slots[found[hkrb_pkg::SLOT_IDX_W-1:0]] <= rd_data;
    end
  end

  // Modifier masks and the changed flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_mask     <= '0;
      weak_mask     <= '0;
      last_modifier <= '0;
      pending       <= 1'b0;
    end else if (emit) begin
      pending <= 1'b0;
      if (!over) begin
        last_modifier <= combined_mod;
        weak_mask     <= '0;
      end
    end else if (accept) begin
      case (act)
        hkrb_pkg::ACT_PRESS,
        hkrb_pkg::ACT_RELEASE: begin
          if (in_range) pending <= 1'b1;
        end
        hkrb_pkg::ACT_SET_HARD: begin
          hard_mask <= hard_mask | ev.mod_mask;
          pending   <= 1'b1;
        end
        hkrb_pkg::ACT_CLR_HARD: begin
          hard_mask <= hard_mask & ~ev.mod_mask;
          pending   <= 1'b1;
        end
        hkrb_pkg::ACT_SET_WEAK: begin
          weak_mask <= weak_mask | ev.mod_mask;
        end
        hkrb_pkg::ACT_CLR_WEAK: begin
          weak_mask <= weak_mask & ~ev.mod_mask;
        end
        hkrb_pkg::ACT_CLR_ALL_WEAK: begin
          weak_mask <= '0;
        end
        default: begin
          pending <= pending;
        end
      endcase
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register: report payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      report.reserved        <= '0;
      report.changed         <= pending;
      report.rolled_over     <= over;
      report.report_modifier <= over ? last_modifier : combined_mod;
      for (int i = 0; i < hkrb_pkg::SLOTS; i++) begin
        report.slot[i] <= over ? hkrb_pkg::ROLLOVER_CODE : slots[i];
      end
    end
  end

  assign m_tdata = report;

endmodule

// ===== sv/hkrb_checker.sv =====
// ----------------------------------------------------------------------------
// HID keyboard report builder checker
// Port-level checks on the report stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_defines.svh"

module hkrb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [hkrb_pkg::ACT_W-1:0]       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [hkrb_pkg::OUT_DATA_W-1:0]  m_tdata
);

  hkrb_pkg::report_t rep;
  logic              build_in;
  logic              all_rollover;
  logic              slots_packed;

  assign rep      = hkrb_pkg::report_t'(m_tdata);
  assign build_in = s_tvalid && s_tready && (s_tuser == hkrb_pkg::ACT_BUILD);

  // Every slot carries the rollover code.
  assign all_rollover = (rep.slot[0] == hkrb_pkg::ROLLOVER_CODE) &&
                        (rep.slot[1] == hkrb_pkg::ROLLOVER_CODE) &&
                        (rep.slot[2] == hkrb_pkg::ROLLOVER_CODE) &&
                        (rep.slot[3] == hkrb_pkg::ROLLOVER_CODE) &&
                        (rep.slot[4] == hkrb_pkg::ROLLOVER_CODE) &&
                        (rep.slot[5] == hkrb_pkg::ROLLOVER_CODE);

  // No empty slot is followed by a filled one.
  assign slots_packed = ((rep.slot[0] != '0) || (rep.slot[1] == '0)) &&
                        ((rep.slot[1] != '0) || (rep.slot[2] == '0)) &&
                        ((rep.slot[2] != '0) || (rep.slot[3] == '0)) &&
                        ((rep.slot[3] != '0) || (rep.slot[4] == '0)) &&
                        ((rep.slot[4] != '0) || (rep.slot[5] == '0));

  // A stalled report holds its contents.
  `HKRB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No further event is taken in the cycle after a build transfer.
  `HKRB_ASSERT_NEXT(a_build_blocks, clk, rst, build_in, !s_tready)

  // A rollover report fills every slot with the rollover code.
  `HKRB_ASSERT_NOW(a_rollover_fill, clk, rst, m_tvalid && rep.rolled_over, all_rollover)

  // In a normal report the keys are packed to the front, empty slots last.
  `HKRB_ASSERT_NOW(a_slots_packed, clk, rst, m_tvalid && !rep.rolled_over, slots_packed)

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (.*);
